/* src/cnv3_pkg.sv */
package cnv3_pkg;

	// Frame limits and data widths
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int PIXEL_BITS = 16;
	localparam int COEF_BITS  = 16;

	// Register and field widths
	localparam int SIZE_BITS  = 11;
	localparam int KROW_BITS  = 48;
	localparam int VALUE_BITS = 36;
	localparam int DATA_BITS  = 48;
	localparam int INDEX_BITS = 3;

	// Counter widths; the row counter runs up to MAX_HEIGHT+1 during the drain
	localparam int COL_BITS = $clog2(MAX_WIDTH);
	localparam int ROW_BITS = $clog2(MAX_HEIGHT + 2);
	localparam int CMP_BITS = ((COL_BITS > SIZE_BITS) ? COL_BITS : SIZE_BITS) + 1;
	localparam int RR_BITS  = ((ROW_BITS > SIZE_BITS) ? ROW_BITS : SIZE_BITS) + 1;

	// Arithmetic widths
	localparam int PROD_BITS   = PIXEL_BITS + COEF_BITS;
	localparam int ROWSUM_BITS = PROD_BITS + 2;

	// Register reset values
	localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = SIZE_BITS'(640);
	localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = SIZE_BITS'(480);
	localparam logic [KROW_BITS-1:0] KROW_TOP_RESET = '0;
	localparam logic [KROW_BITS-1:0] KROW_MID_RESET = KROW_BITS'(8192);
	localparam logic [KROW_BITS-1:0] KROW_BOT_RESET = '0;

	// Register map
	typedef enum logic [INDEX_BITS-1:0] {
		REG_IMAGE_WIDTH    = 3'd0,
		REG_IMAGE_HEIGHT   = 3'd1,
		REG_KERNEL_ROW_TOP = 3'd2,
		REG_KERNEL_ROW_MID = 3'd3,
		REG_KERNEL_ROW_BOT = 3'd4
	} reg_index_t;

	// Channel payloads
	typedef struct packed {
		logic signed [PIXEL_BITS-1:0] pixel;
		logic                         flush;
	} pixel_in_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] value;
		logic                         last;
	} result_t;

	// Border flags of one output position
	typedef struct packed {
		logic top_off;
		logic bot_off;
		logic left_off;
		logic right_off;
		logic last;
	} border_t;

endpackage

/* src/conv3x3_zero_border.sv */
// Streaming 3x3 convolution with zero padding. Pixels of an image_width x
// image_height frame enter in raster order, one item per clock, and the block
// gives one 36-bit Q.13 sum per pixel; the sum for pixel (r,c) leaves on the
// item that carries raster position r*W+c+W+1, so after the last pixel the
// source sends W+1 flush items to drain the frame, and the final result has
// last set. The rate is one item per clock while in_stall is low, set by the
// single read and single write port of each of the two 16-bit line RAMs (one
// read-modify-write per item, with forwarding when the same column is hit on
// consecutive items). The RAM read is at the accepting edge, then window
// update, multiply, row sums, and the final sum into the output register,
// where out_valid rises. A two-entry output (register plus skid) keeps taking
// items while a result waits; in_stall rises only when both are full. The line
// RAMs need no clearing pass after reset: border masking keeps stale contents
// out of every sum. Writing image_width or image_height restarts the frame;
// the user must make writes only while the block is idle; it does not check.
module conv3x3_zero_border (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wen,
	input  logic [cnv3_pkg::INDEX_BITS-1:0]      cfg_index,
	input  logic [cnv3_pkg::DATA_BITS-1:0]       cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  cnv3_pkg::pixel_in_t                  in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output cnv3_pkg::result_t                    out_data
);

	localparam int PB  = cnv3_pkg::PIXEL_BITS;
	localparam int CB  = cnv3_pkg::COEF_BITS;
	localparam int SB  = cnv3_pkg::SIZE_BITS;
	localparam int COLB = cnv3_pkg::COL_BITS;
	localparam int ROWB = cnv3_pkg::ROW_BITS;
	localparam int CMPB = cnv3_pkg::CMP_BITS;
	localparam int RRB  = cnv3_pkg::RR_BITS;
	localparam int PRB  = cnv3_pkg::PROD_BITS;
	localparam int RSB  = cnv3_pkg::ROWSUM_BITS;
	localparam int VB   = cnv3_pkg::VALUE_BITS;
	localparam int KB   = cnv3_pkg::KROW_BITS;

	// Configuration registers
	logic [SB-1:0] width_q;
	logic [SB-1:0] height_q;
	logic [KB-1:0] krow_q [3];

	// Frame position of the next item
	logic [COLB-1:0] col_q;
	logic [ROWB-1:0] row_q;

	// Line RAMs and their read registers
	logic signed [PB-1:0] mem_a [cnv3_pkg::MAX_WIDTH];
	logic signed [PB-1:0] mem_b [cnv3_pkg::MAX_WIDTH];
	logic signed [PB-1:0] rd_a_q;
	logic signed [PB-1:0] rd_b_q;

	// 3x3 window
	logic signed [PB-1:0] win_q [3][3];

	// Pipeline
	logic                  vld_s1, res_s1, fwd_s1;
	logic [COLB-1:0]       addr_s1;
	logic signed [PB-1:0]  bot_s1;
	cnv3_pkg::border_t     ctl_s1;
	logic                  vld_s2, res_s2, last_s2;
	logic signed [PB-1:0]  mid_s2, bot_s2;
	logic signed [PB-1:0]  tap_s2 [3][3];
	logic                  res_s3, last_s3;
	logic signed [PRB-1:0] prod_s3 [3][3];
	logic                  res_s4, last_s4;
	logic signed [RSB-1:0] rowsum_s4 [3];

	// Output register and skid entry
	logic                  out_valid_q, skid_valid_q;
	cnv3_pkg::result_t     out_q, skid_q;

	logic                  en, accept;
	logic [SB-1:0]         w_eff, h_eff;
	logic                  col_zero, emit;
	logic [CMPB-1:0]       col_nx;
	logic signed [RRB-1:0] rr;
	cnv3_pkg::border_t     ctl_s0;
	logic                  restart;
	logic signed [PB-1:0]  mid_eff, top_eff;
	logic signed [PB-1:0]  win_next [3][3];
	logic signed [CB-1:0]  coef [3][3];
	cnv3_pkg::result_t     res_new;
	logic                  load_out, load_skid;

	assign en       = !skid_valid_q;
	assign accept   = in_valid && !in_stall;
	assign in_stall = skid_valid_q;

	// Size clamping: zero counts as one, oversize counts as the maximum
	always_comb begin
		if (width_q == '0)
			w_eff = SB'(1);
		else if (int'(width_q) > cnv3_pkg::MAX_WIDTH)
			w_eff = SB'(cnv3_pkg::MAX_WIDTH);
		else
			w_eff = width_q;
		if (height_q == '0)
			h_eff = SB'(1);
		else if (int'(height_q) > cnv3_pkg::MAX_HEIGHT)
			h_eff = SB'(cnv3_pkg::MAX_HEIGHT);
		else
			h_eff = height_q;
	end

	// Output position and border flags for the incoming item
	always_comb begin
		col_zero = (col_q == '0);
		col_nx   = CMPB'(col_q) + CMPB'(1);
		rr       = $signed(RRB'(row_q)) - (col_zero ? RRB'(2) : RRB'(1));
		emit     = !rr[RRB-1] && (rr < $signed(RRB'(h_eff)));
		ctl_s0.top_off   = (rr == '0);
		ctl_s0.bot_off   = (rr == $signed(RRB'(h_eff) - RRB'(1)));
		ctl_s0.right_off = col_zero;
		ctl_s0.left_off  = col_zero ? (w_eff == SB'(1)) : (col_q == COLB'(1));
		ctl_s0.last      = ctl_s0.bot_off && ctl_s0.right_off;
	end

	assign restart = cfg_wen && ((cfg_index == cnv3_pkg::REG_IMAGE_WIDTH) ||
		(cfg_index == cnv3_pkg::REG_IMAGE_HEIGHT));

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= cnv3_pkg::WIDTH_RESET;
			height_q  <= cnv3_pkg::HEIGHT_RESET;
			krow_q[0] <= cnv3_pkg::KROW_TOP_RESET;
			krow_q[1] <= cnv3_pkg::KROW_MID_RESET;
			krow_q[2] <= cnv3_pkg::KROW_BOT_RESET;
		end else if (cfg_wen) begin
			case (cfg_index)
				cnv3_pkg::REG_IMAGE_WIDTH:    width_q   <= cfg_data[SB-1:0];
				cnv3_pkg::REG_IMAGE_HEIGHT:   height_q  <= cfg_data[SB-1:0];
				cnv3_pkg::REG_KERNEL_ROW_TOP: krow_q[0] <= cfg_data[KB-1:0];
				cnv3_pkg::REG_KERNEL_ROW_MID: krow_q[1] <= cfg_data[KB-1:0];
				cnv3_pkg::REG_KERNEL_ROW_BOT: krow_q[2] <= cfg_data[KB-1:0];
				default: ;
			endcase
		end
	end

	// Raster position; the final result of a frame wraps it to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (emit && ctl_s0.last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_nx >= CMPB'(w_eff)) begin
				col_q <= '0;
				row_q <= row_q + ROWB'(1);
			end else begin
				col_q <= col_nx[COLB-1:0];
			end
		end
	end

	// Pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			res_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			res_s2 <= 1'b0;
			res_s3 <= 1'b0;
			res_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= accept;
			res_s1 <= accept && emit;
			fwd_s1 <= accept && vld_s1 && (col_q == addr_s1);
			vld_s2 <= vld_s1;
			res_s2 <= res_s1;
			res_s3 <= res_s2;
			res_s4 <= res_s3;
		end
	end

	// Line RAMs: row above goes to B, new pixel goes to A
	always_ff @(posedge clk) begin
		if (en && vld_s1) begin
			mem_a[addr_s1] <= bot_s1;
			mem_b[addr_s1] <= mid_eff;
		end
		if (en) begin
			rd_a_q <= mem_a[col_q];
			rd_b_q <= mem_b[col_q];
		end
	end

	// Same column on consecutive items: take the previous item's write data
	assign mid_eff = fwd_s1 ? bot_s2 : rd_a_q;
	assign top_eff = fwd_s1 ? mid_s2 : rd_b_q;

	// Window shift
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			win_next[i][0] = win_q[i][1];
			win_next[i][1] = win_q[i][2];
		end
		win_next[0][2] = top_eff;
		win_next[1][2] = mid_eff;
		win_next[2][2] = bot_s1;
	end

	// Kernel coefficients
	always_comb begin
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				coef[i][j] = krow_q[i][CB*j +: CB];
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (en) begin
			addr_s1 <= col_q;
			bot_s1  <= in_data.flush ? '0 : in_data.pixel;
			ctl_s1  <= ctl_s0;

			if (vld_s1) begin
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 3; j++)
						win_q[i][j] <= win_next[i][j];
			end
			mid_s2  <= mid_eff;
			bot_s2  <= bot_s1;
			last_s2 <= ctl_s1.last;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					tap_s2[i][j] <= ((i == 0 && ctl_s1.top_off) ||
						(i == 2 && ctl_s1.bot_off) ||
						(j == 0 && ctl_s1.left_off) ||
						(j == 2 && ctl_s1.right_off)) ? '0 : win_next[i][j];

			last_s3 <= last_s2;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					prod_s3[i][j] <= PRB'(tap_s2[i][j]) * PRB'(coef[i][j]);

			last_s4 <= last_s3;
			for (int i = 0; i < 3; i++)
				rowsum_s4[i] <= RSB'(prod_s3[i][0]) + RSB'(prod_s3[i][1]) +
					RSB'(prod_s3[i][2]);
		end
	end

	// Final sum and output hand-off
	always_comb begin
		res_new.value = VB'(rowsum_s4[0]) + VB'(rowsum_s4[1]) + VB'(rowsum_s4[2]);
		res_new.last  = last_s4;
		load_out  = skid_valid_q ? !out_stall : (res_s4 && (!out_valid_q || !out_stall));
		load_skid = !skid_valid_q && res_s4 && out_valid_q && out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (load_skid)
				skid_valid_q <= 1'b1;
			else if (!out_stall)
				skid_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out)
			out_q <= skid_valid_q ? skid_q : res_new;
		if (load_skid)
			skid_q <= res_new;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef ASSERT_OFF
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds an item while the output register is empty");

	a_fwd_source: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> (vld_s1 && vld_s2))
		else $error("forwarding selected without a preceding item in flight");

	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		CMPB'(col_q) < CMPB'(w_eff))
		else $error("column position beyond image width");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |=> ($stable(vld_s1) && $stable(res_s4) && $stable(col_q)))
		else $error("pipeline moved while the output side was full");
`endif

endmodule
